// File: design/track_run_sample_expander_assert.svh
// ----------------------------------------------------------------------------
// track run sample expander assertion macros
// shared property templates for the expander's checks
// ----------------------------------------------------------------------------
`ifndef TRACK_RUN_SAMPLE_EXPANDER_ASSERT_SVH
`define TRACK_RUN_SAMPLE_EXPANDER_ASSERT_SVH

// same-cycle implication
`define TSE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("expander check failed: same-cycle implication");

// next-cycle implication
`define TSE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("expander check failed: next-cycle implication");

`endif

// File: design/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// types and constants shared by the track run sample expander
// ----------------------------------------------------------------------------
`default_nettype none

package tse_pkg;

   localparam int REQ_DATA_W = 400;
   localparam int RSP_DATA_W = 216;

   localparam logic [1:0] MODE_FRAG   = 2'd0;
   localparam logic [1:0] MODE_RUN    = 2'd1;
   localparam logic [1:0] MODE_SAMPLE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NEG_POS  = 2'd1;
   localparam logic [1:0] STATUS_LIMIT    = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE  = 2'd3;

   localparam int RF_DELTA_BIT       = 0;
   localparam int RF_LEAD_FLAGS_BIT  = 2;
   localparam int RF_DURATION_BIT    = 8;
   localparam int RF_SIZE_BIT        = 9;
   localparam int RF_FLAGS_BIT       = 10;
   localparam int NON_SYNC_BIT       = 16;

   typedef struct packed {
      logic [1:0]         mode;
      logic [31:0]        track_num;
      logic [63:0]        base_pos;
      logic               base_present;
      logic [47:0]        moof_pos;
      logic [31:0]        duration;
      logic [31:0]        size;
      logic [63:0]        dts_start;
      logic [23:0]        run_flags;
      logic [31:0]        sample_count;
      logic signed [31:0] run_delta;
      logic [31:0]        sample_flags;
   } item_type;

   typedef struct packed {
      logic [47:0] sample_offset;
      logic [31:0] sample_len;
      logic [31:0] sample_duration;
      logic [63:0] sample_decode_time;
      logic [31:0] sample_track;
      logic        is_sync;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic res_valid;
      logic failed;
   } core_status_type;

endpackage

`default_nettype wire

// File: design/tse_core.sv
// ----------------------------------------------------------------------------
// tse_core
// fragment and run state with the single-pass sample expansion logic
// ----------------------------------------------------------------------------
`default_nettype none

module tse_core #(
   parameter int unsigned MAX_SAMPLES = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire tse_pkg::item_type        item,
   input  wire logic [47:0]              file_len,
   output tse_pkg::core_status_type      stat,
   output tse_pkg::result_type           result
);
   import tse_pkg::*;

   localparam int TOTAL_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [32:0] MAX_LIM = 33'(MAX_SAMPLES);

   logic [63:0]        cursor_ff, cursor_in;
   logic [63:0]        dacc_ff, dacc_in;
   logic [31:0]        track_ff, track_in;
   logic [31:0]        def_dur_ff, def_dur_in;
   logic [31:0]        def_size_ff, def_size_in;
   logic [63:0]        base_ff, base_in;
   logic               base_valid_ff, base_valid_in;
   logic [47:0]        start_ff, start_in;
   logic               rf_dur_ff, rf_dur_in;
   logic               rf_size_ff, rf_size_in;
   logic               rf_flags_ff, rf_flags_in;
   logic               first_nonsync_ff, first_nonsync_in;
   logic [31:0]        left_ff, left_in;
   logic               at_first_ff, at_first_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               failed_ff, failed_in;

   logic [63:0] frag_base;
   logic [32:0] lim_sum;
   logic        lim_err;
   logic [32:0] mag;
   logic        neg_err;
   logic [64:0] pos_sum;
   logic [63:0] run_start;
   logic [31:0] dur;
   logic [31:0] sz;
   logic        nonsync;
   logic [64:0] room;
   logic        outside;
   logic        res_valid;
   result_type  res;

   always_comb begin
      frag_base = base_valid_ff ? base_ff : {16'd0, start_ff};
      lim_sum   = 33'(total_ff) + {1'b0, item.sample_count};
      lim_err   = lim_sum > MAX_LIM;
      mag       = {1'b0, ~item.run_delta} + 33'd1;
      neg_err   = item.run_delta[31] && (frag_base < {31'd0, mag});
      pos_sum   = {1'b0, frag_base} + {33'd0, item.run_delta};
      if (!item.run_flags[RF_DELTA_BIT]) begin
         run_start = cursor_ff;
      end else if (item.run_delta[31]) begin
         run_start = frag_base - {31'd0, mag};
      end else if (pos_sum[64]) begin
         run_start = '1;
      end else begin
         run_start = pos_sum[63:0];
      end
      dur     = rf_dur_ff ? item.duration : def_dur_ff;
      sz      = rf_size_ff ? item.size : def_size_ff;
      nonsync = rf_flags_ff ? item.sample_flags[NON_SYNC_BIT]
                            : (at_first_ff && first_nonsync_ff);
      room    = {17'd0, file_len} - {1'b0, cursor_ff};
      outside = room[64] || (48'(sz) > room[47:0]);
   end

   always_comb begin
      cursor_in        = cursor_ff;
      dacc_in          = dacc_ff;
      track_in         = track_ff;
      def_dur_in       = def_dur_ff;
      def_size_in      = def_size_ff;
      base_in          = base_ff;
      base_valid_in    = base_valid_ff;
      start_in         = start_ff;
      rf_dur_in        = rf_dur_ff;
      rf_size_in       = rf_size_ff;
      rf_flags_in      = rf_flags_ff;
      first_nonsync_in = first_nonsync_ff;
      left_in          = left_ff;
      at_first_in      = at_first_ff;
      total_in         = total_ff;
      failed_in        = failed_ff;
      res_valid        = 1'b0;
      res              = '0;
      if (!failed_ff) begin
         case (item.mode)
            MODE_FRAG: begin
               track_in      = item.track_num;
               base_in       = item.base_pos;
               base_valid_in = item.base_present;
               start_in      = item.moof_pos;
               def_dur_in    = item.duration;
               def_size_in   = item.size;
               cursor_in     = item.base_present ? item.base_pos
                                                 : {16'd0, item.moof_pos};
               dacc_in       = item.dts_start;
               left_in       = '0;
               at_first_in   = 1'b0;
            end
            MODE_RUN: begin
               if (lim_err) begin
                  res_valid  = 1'b1;
                  res.status = STATUS_LIMIT;
                  failed_in  = 1'b1;
                  left_in    = '0;
               end else if (item.run_flags[RF_DELTA_BIT] && neg_err) begin
                  res_valid  = 1'b1;
                  res.status = STATUS_NEG_POS;
                  failed_in  = 1'b1;
                  left_in    = '0;
               end else begin
                  cursor_in        = run_start;
                  rf_dur_in        = item.run_flags[RF_DURATION_BIT];
                  rf_size_in       = item.run_flags[RF_SIZE_BIT];
                  rf_flags_in      = item.run_flags[RF_FLAGS_BIT];
                  first_nonsync_in = item.run_flags[RF_LEAD_FLAGS_BIT]
                                     && item.sample_flags[NON_SYNC_BIT];
                  left_in          = item.sample_count;
                  at_first_in      = 1'b1;
               end
            end
            MODE_SAMPLE: begin
               if (left_ff != '0) begin
                  res_valid = 1'b1;
                  if (outside) begin
                     res.status = STATUS_OUTSIDE;
                     failed_in  = 1'b1;
                     left_in    = '0;
                  end else begin
                     res.sample_offset      = cursor_ff[47:0];
                     res.sample_len         = sz;
                     res.sample_duration    = dur;
                     res.sample_decode_time = dacc_ff;
                     res.sample_track       = track_ff;
                     res.is_sync            = !nonsync;
                     res.status             = STATUS_OK;
                     res.last               = left_ff == 32'd1;
                     cursor_in   = cursor_ff + {32'd0, sz};
                     dacc_in     = dacc_ff + {32'd0, dur};
                     left_in     = left_ff - 32'd1;
                     at_first_in = 1'b0;
                     total_in    = total_ff + TOTAL_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff        <= '0;
         dacc_ff          <= '0;
         track_ff         <= '0;
         def_dur_ff       <= '0;
         def_size_ff      <= '0;
         base_ff          <= '0;
         base_valid_ff    <= 1'b0;
         start_ff         <= '0;
         rf_dur_ff        <= 1'b0;
         rf_size_ff       <= 1'b0;
         rf_flags_ff      <= 1'b0;
         first_nonsync_ff <= 1'b0;
         left_ff          <= '0;
         at_first_ff      <= 1'b0;
         total_ff         <= '0;
         failed_ff        <= 1'b0;
      end else if (fire) begin
         cursor_ff        <= cursor_in;
         dacc_ff          <= dacc_in;
         track_ff         <= track_in;
         def_dur_ff       <= def_dur_in;
         def_size_ff      <= def_size_in;
         base_ff          <= base_in;
         base_valid_ff    <= base_valid_in;
         start_ff         <= start_in;
         rf_dur_ff        <= rf_dur_in;
         rf_size_ff       <= rf_size_in;
         rf_flags_ff      <= rf_flags_in;
         first_nonsync_ff <= first_nonsync_in;
         left_ff          <= left_in;
         at_first_ff      <= at_first_in;
         total_ff         <= total_in;
         failed_ff        <= failed_in;
      end
   end

   assign stat.res_valid = res_valid;
   assign stat.failed    = failed_ff;
   assign result         = res;

endmodule

`default_nettype wire

// File: design/track_run_sample_expander.sv
// ----------------------------------------------------------------------------
// track_run_sample_expander
// expands fragmented mp4 track runs into one record per sample
// ----------------------------------------------------------------------------
// channel  direction  contents
// req_     in         fragment header, run header or sample entry (mode in tuser)
// rsp_     out        sample record or error record (status in tuser)
// csr_     in         file size write
//
// one item per cycle sustained unless a record meets a stalled rsp; a req
// item is captured in the input register, passes the core logic, and its
// record is held in the result register, from which rsp is driven
// reset clears all fragment and run state, the error latch and file size
// a stalled rsp holds its record; req keeps flowing until an item that
// makes a record meets a full result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "track_run_sample_expander_assert.svh"

module track_run_sample_expander #(
   parameter int unsigned MAX_SAMPLES = 65536
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // track_num, base_pos, base_present, moof_pos, duration, size,
   // dts_start, run_flags, sample_count, run_delta, sample_flags, zero pad
   input  wire logic [tse_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  wire logic [1:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // sample_offset, sample_len, sample_duration, sample_decode_time,
   // sample_track, is_sync, zero pad
   output logic [tse_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  wire logic                           csr_wen,
   input  wire logic [47:0]                    csr_wdata
);
   import tse_pkg::*;

   item_type        req_item;
   item_type        item_ff;
   logic            in_valid_ff, in_valid_in;
   logic            fire;
   core_status_type core_stat;
   result_type      core_res;
   result_type      rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [47:0]     file_len_ff;

   always_comb begin
      req_item.mode         = req_tuser;
      req_item.track_num    = req_tdata[31:0];
      req_item.base_pos     = req_tdata[95:32];
      req_item.base_present = req_tdata[96];
      req_item.moof_pos     = req_tdata[144:97];
      req_item.duration     = req_tdata[176:145];
      req_item.size         = req_tdata[208:177];
      req_item.dts_start    = req_tdata[272:209];
      req_item.run_flags    = req_tdata[296:273];
      req_item.sample_count = req_tdata[328:297];
      req_item.run_delta    = req_tdata[360:329];
      req_item.sample_flags = req_tdata[392:361];
   end

   always_comb begin
      fire         = in_valid_ff && (!core_stat.res_valid || !rsp_valid_ff || rsp_tready);
      req_tready   = !in_valid_ff || fire;
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire && core_stat.res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   tse_core #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .file_len  (file_len_ff),
      .stat      (core_stat),
      .result    (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         file_len_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            file_len_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
      if (fire && core_stat.res_valid) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.is_sync, rsp_ff.sample_track, rsp_ff.sample_decode_time,
                        rsp_ff.sample_duration, rsp_ff.sample_len, rsp_ff.sample_offset};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   `TSE_ASSERT_IMP(a_err_rec_zero, clock, reset, rsp_tvalid && (rsp_tuser != STATUS_OK), rsp_tdata == '0 && !rsp_tlast)
   `TSE_ASSERT_NXT(a_fail_sticky, clock, reset, core_stat.failed, core_stat.failed)
   `TSE_ASSERT_IMP(a_fail_silent, clock, reset, core_stat.failed, !core_stat.res_valid)
   `TSE_ASSERT_IMP(a_hold_on_full, clock, reset, rsp_tvalid && !rsp_tready && core_stat.res_valid, !fire)

endmodule

`default_nettype wire
